// ----- rtl/i2c_transfer_event_sequencer_top_macros.svh -----
// ----------------------------------------------------------------------------
// I2C transfer event sequencer assertion macros
// Shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef I2C_TRANSFER_EVENT_SEQUENCER_TOP_MACROS_SVH
`define I2C_TRANSFER_EVENT_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ITES_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ITES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ites_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer event sequencer package
// Action and state codes, flag positions and the item and result types
// ----------------------------------------------------------------------------
package ites_pkg;

    typedef enum logic [2:0] {
        ACT_MASTER_WRITE  = 3'd0,
        ACT_MASTER_READ   = 3'd1,
        ACT_SLAVE_SEND    = 3'd2,
        ACT_SLAVE_RECEIVE = 3'd3,
        ACT_EVENT         = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        MODE_READY = 3'd0,
        MODE_MTX   = 3'd1,
        MODE_MRX   = 3'd2,
        MODE_STX   = 3'd3,
        MODE_SRX   = 3'd4
    } mode_t;

    // status flag bit positions
    localparam int FLG_ADDR = 0;
    localparam int FLG_TXE  = 1;
    localparam int FLG_RXNE = 2;
    localparam int FLG_STOP = 3;
    localparam int FLG_NACK = 4;
    localparam int FLG_DIR  = 5;

    // interrupt enable bit positions
    localparam int EN_TX   = 0;
    localparam int EN_RX   = 1;
    localparam int EN_ADDR = 2;
    localparam int EN_NACK = 3;
    localparam int EN_STOP = 4;

    // acknowledge action bit positions
    localparam int ACK_ADDR  = 0;
    localparam int ACK_STOP  = 1;
    localparam int ACK_NACK  = 2;
    localparam int ACK_FLUSH = 3;

    localparam logic [7:0] FILLER_BYTE = 8'd3;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] transfer_length;
        logic [6:0] target_address;
        logic       bus_busy;
        logic [5:0] status_flags;
        logic [7:0] received_byte;
        logic [7:0] send_byte;
    } item_t;

    typedef struct packed {
        mode_t      mode;
        logic [7:0] count;
        logic [4:0] mask;
    } seq_state_t;

    typedef struct packed {
        logic       start_accepted;
        logic       start_request;
        logic [6:0] start_address;
        logic       tx_write;
        logic [7:0] tx_value;
        logic       rx_store;
        logic [7:0] rx_value;
        logic [3:0] ack_actions;
        logic [4:0] irq_enables;
        logic [2:0] transfer_state;
        logic [7:0] remaining_bytes;
    } result_t;

endpackage

// ----- rtl/ites_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer event sequencer step logic
// Next state and result for one item, given the current sequencer state
// ----------------------------------------------------------------------------
module ites_step import ites_pkg::*; (
    input  item_t      item,
    input  seq_state_t cur,
    output seq_state_t nxt,
    output result_t    res
);

    logic [7:0] count_dec;
    logic       count_nz;
    logic       count_last;

    assign count_dec  = cur.count - 8'd1;
    assign count_nz   = (cur.count != 8'd0);
    assign count_last = (cur.count == 8'd1);

    always_comb begin
        nxt = cur;
        res = '0;

        case (action_t'(item.action))
            ACT_MASTER_WRITE, ACT_MASTER_READ, ACT_SLAVE_SEND, ACT_SLAVE_RECEIVE: begin
                if ((cur.mode == MODE_READY) && !item.bus_busy) begin
                    res.start_accepted = 1'b1;
                    nxt.count          = item.transfer_length;
                    case (action_t'(item.action))
                        ACT_MASTER_WRITE: begin
                            nxt.mode              = MODE_MTX;
                            nxt.mask[EN_NACK]     = 1'b1;
                            nxt.mask[EN_TX]       = 1'b1;
                            res.start_request     = 1'b1;
                            res.start_address     = item.target_address;
                        end
                        ACT_MASTER_READ: begin
                            nxt.mode              = MODE_MRX;
                            nxt.mask[EN_NACK]     = 1'b1;
                            nxt.mask[EN_RX]       = 1'b1;
                            res.start_request     = 1'b1;
                            res.start_address     = item.target_address;
                        end
                        ACT_SLAVE_SEND: begin
                            nxt.mode          = MODE_STX;
                            nxt.mask[EN_TX]   = 1'b1;
                            nxt.mask[EN_ADDR] = 1'b1;
                            nxt.mask[EN_NACK] = 1'b1;
                            nxt.mask[EN_STOP] = 1'b1;
                        end
                        default: begin
                            nxt.mode          = MODE_SRX;
                            nxt.mask[EN_RX]   = 1'b1;
                            nxt.mask[EN_ADDR] = 1'b1;
                            nxt.mask[EN_NACK] = 1'b1;
                            nxt.mask[EN_STOP] = 1'b1;
                        end
                    endcase
                end
            end
            ACT_EVENT: begin
                // fixed priority: address, tx ready, rx full, stop, nack
                if (item.status_flags[FLG_ADDR]) begin
                    res.ack_actions[ACK_ADDR]  = 1'b1;
                    res.ack_actions[ACK_FLUSH] = item.status_flags[FLG_DIR];
                end else if (item.status_flags[FLG_TXE]) begin
                    if ((cur.mode == MODE_MTX) || (cur.mode == MODE_STX)) begin
                        res.tx_write = 1'b1;
                        if (count_nz) begin
                            res.tx_value = item.send_byte;
                            nxt.count    = count_dec;
                            if (count_last && (cur.mode == MODE_MTX)) begin
                                nxt.mode = MODE_READY;
                            end
                        end else begin
                            // underrun
                            res.tx_value = FILLER_BYTE;
                        end
                    end
                end else if (item.status_flags[FLG_RXNE]) begin
                    if (((cur.mode == MODE_MRX) || (cur.mode == MODE_SRX)) && count_nz) begin
                        res.rx_store = 1'b1;
                        res.rx_value = item.received_byte;
                        nxt.count    = count_dec;
                        if (count_last && (cur.mode == MODE_MRX)) begin
                            nxt.mode = MODE_READY;
                        end
                    end
                end else if (item.status_flags[FLG_STOP]) begin
                    res.ack_actions[ACK_STOP] = 1'b1;
                    if (cur.mode == MODE_SRX) begin
                        nxt.mask[EN_RX] = 1'b0;
                    end else if (cur.mode == MODE_STX) begin
                        nxt.mask[EN_TX] = 1'b0;
                    end
                    nxt.mode = MODE_READY;
                end else if (item.status_flags[FLG_NACK]) begin
                    if ((cur.mode == MODE_MTX) || (cur.mode == MODE_MRX)) begin
                        res.ack_actions[ACK_NACK] = 1'b1;
                        nxt.count                 = 8'd0;
                        nxt.mode                  = MODE_READY;
                    end else if (cur.mode == MODE_STX) begin
                        // slave stays in tx when the count is already spent
                        res.ack_actions[ACK_NACK] = 1'b1;
                        nxt.count                 = 8'd0;
                        if (count_nz) begin
                            nxt.mode = MODE_READY;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        res.irq_enables     = nxt.mask;
        res.transfer_state  = nxt.mode;
        res.remaining_bytes = nxt.count;
    end

endmodule

// ----- rtl/i2c_transfer_event_sequencer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer event sequencer top level
// Input register, step logic with sequencer state, result register
// ----------------------------------------------------------------------------
// Takes one start action or interrupt event per clock and returns exactly one
// result per item. An item is held in an input register, then the step logic
// updates the sequencer state (mode, byte count, interrupt enables) and loads
// the result register when that register is empty or being drained.
// Sustained rate is one item per cycle while the result side is not stalled,
// as the state register is updated once per item; back-pressure on the result
// side stalls the input only when both registers are full.
module i2c_transfer_event_sequencer_top import ites_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_action,
    input  logic [7:0] s_transfer_length,
    input  logic [6:0] s_target_address,
    input  logic       s_bus_busy,
    input  logic [5:0] s_status_flags,
    input  logic [7:0] s_received_byte,
    input  logic [7:0] s_send_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_start_accepted,
    output logic       m_start_request,
    output logic [6:0] m_start_address,
    output logic       m_tx_write,
    output logic [7:0] m_tx_value,
    output logic       m_rx_store,
    output logic [7:0] m_rx_value,
    output logic [3:0] m_ack_actions,
    output logic [4:0] m_irq_enables,
    output logic [2:0] m_transfer_state,
    output logic [7:0] m_remaining_bytes
);

    item_t      item_reg;
    logic       item_valid_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    result_reg;
    result_t    result_next;
    logic       out_valid_reg;
    logic       advance;

    // stage 2 can take a new result when empty or being drained
    assign advance = item_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !item_valid_reg || advance;

    ites_step u_step (
        .item (item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.action          <= s_action;
            item_reg.transfer_length <= s_transfer_length;
            item_reg.target_address  <= s_target_address;
            item_reg.bus_busy        <= s_bus_busy;
            item_reg.status_flags    <= s_status_flags;
            item_reg.received_byte   <= s_received_byte;
            item_reg.send_byte       <= s_send_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode  <= MODE_READY;
            state_reg.count <= 8'd0;
            state_reg.mask  <= 5'd0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_start_accepted  = result_reg.start_accepted;
    assign m_start_request   = result_reg.start_request;
    assign m_start_address   = result_reg.start_address;
    assign m_tx_write        = result_reg.tx_write;
    assign m_tx_value        = result_reg.tx_value;
    assign m_rx_store        = result_reg.rx_store;
    assign m_rx_value        = result_reg.rx_value;
    assign m_ack_actions     = result_reg.ack_actions;
    assign m_irq_enables     = result_reg.irq_enables;
    assign m_transfer_state  = result_reg.transfer_state;
    assign m_remaining_bytes = result_reg.remaining_bytes;

endmodule

// ----- rtl/ites_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer event sequencer port checker
// Result consistency and output hold checks, bound to the top level
// ----------------------------------------------------------------------------
`include "i2c_transfer_event_sequencer_top_macros.svh"

module ites_checker import ites_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_start_accepted,
    input logic       m_start_request,
    input logic       m_tx_write,
    input logic       m_rx_store,
    input logic [3:0] m_ack_actions,
    input logic [2:0] m_transfer_state,
    input logic [7:0] m_remaining_bytes
);

    // a start request only comes with an accepted master start
    `ITES_ASSERT_NOW(a_req_needs_accept, m_valid && m_start_request, m_start_accepted && ((m_transfer_state == MODE_MTX) || (m_transfer_state == MODE_MRX)), "start request without master start")

    // an accepted start moves no data and clears no flag
    `ITES_ASSERT_NOW(a_start_no_data, m_valid && m_start_accepted, !m_tx_write && !m_rx_store && (m_ack_actions == 4'd0) && (m_transfer_state != MODE_READY), "accepted start with data or ack")

    // one event services one flag only
    `ITES_ASSERT_NOW(a_one_service, m_valid, !(m_tx_write && m_rx_store) && !(m_rx_store && (m_ack_actions != 4'd0)), "more than one flag serviced")

    // a stalled result holds its state fields
    `ITES_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_transfer_state) && $stable(m_remaining_bytes), "stalled result changed")

endmodule

bind i2c_transfer_event_sequencer_top ites_checker u_ites_checker (.*);

// ----- test/ites_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer event sequencer scoreboard
// Tracks mode, byte count and enables, and checks every result in order
// ----------------------------------------------------------------------------
package ites_tb_pkg;
    import ites_pkg::*;

    class sequencer_scoreboard;
        mode_t       mode;
        logic [7:0]  count;
        logic [4:0]  mask;
        result_t     awaited[$];
        int unsigned n_outcomes;
        int unsigned n_errors;
        int unsigned n_starts;
        int unsigned n_tx;
        int unsigned n_filler;
        int unsigned n_rx;
        int unsigned n_stops;

        function new();
            mode       = MODE_READY;
            count      = '0;
            mask       = '0;
            n_outcomes = 0;
            n_errors   = 0;
            n_starts   = 0;
            n_tx       = 0;
            n_filler   = 0;
            n_rx       = 0;
            n_stops    = 0;
        endfunction

        // advance the sequencer by one accepted transfer and queue its result
        function void note_item(item_t it);
            result_t r;
            r = '0;
            if (it.action <= ACT_SLAVE_RECEIVE) begin
                if (mode == MODE_READY && !it.bus_busy) begin
                    r.start_accepted = 1'b1;
                    count = it.transfer_length;
                    n_starts++;
                    case (it.action)
                        ACT_MASTER_WRITE: begin
                            mode = MODE_MTX;
                            mask[EN_NACK] = 1'b1;
                            mask[EN_TX]   = 1'b1;
                            r.start_request = 1'b1;
                            r.start_address = it.target_address;
                        end
                        ACT_MASTER_READ: begin
                            mode = MODE_MRX;
                            mask[EN_NACK] = 1'b1;
                            mask[EN_RX]   = 1'b1;
                            r.start_request = 1'b1;
                            r.start_address = it.target_address;
                        end
                        ACT_SLAVE_SEND: begin
                            mode = MODE_STX;
                            mask[EN_TX]   = 1'b1;
                            mask[EN_ADDR] = 1'b1;
                            mask[EN_NACK] = 1'b1;
                            mask[EN_STOP] = 1'b1;
                        end
                        default: begin
                            mode = MODE_SRX;
                            mask[EN_RX]   = 1'b1;
                            mask[EN_ADDR] = 1'b1;
                            mask[EN_NACK] = 1'b1;
                            mask[EN_STOP] = 1'b1;
                        end
                    endcase
                end
            end else if (it.action == ACT_EVENT) begin
                // flags are serviced strictly by priority, one per event
                if (it.status_flags[FLG_ADDR]) begin
                    r.ack_actions[ACK_ADDR] = 1'b1;
                    if (it.status_flags[FLG_DIR])
                        r.ack_actions[ACK_FLUSH] = 1'b1;
                end else if (it.status_flags[FLG_TXE]) begin
                    if (mode == MODE_MTX || mode == MODE_STX) begin
                        r.tx_write = 1'b1;
                        n_tx++;
                        if (count != 8'd0) begin
                            r.tx_value = it.send_byte;
                            count = count - 8'd1;
                            if (count == 8'd0 && mode == MODE_MTX)
                                mode = MODE_READY;
                        end else begin
                            r.tx_value = FILLER_BYTE;
                            n_filler++;
                        end
                    end
                end else if (it.status_flags[FLG_RXNE]) begin
                    if ((mode == MODE_MRX || mode == MODE_SRX) && count != 8'd0) begin
                        r.rx_store = 1'b1;
                        r.rx_value = it.received_byte;
                        n_rx++;
                        count = count - 8'd1;
                        if (count == 8'd0 && mode == MODE_MRX)
                            mode = MODE_READY;
                    end
                end else if (it.status_flags[FLG_STOP]) begin
                    r.ack_actions[ACK_STOP] = 1'b1;
                    n_stops++;
                    if (mode == MODE_SRX)
                        mask[EN_RX] = 1'b0;
                    else if (mode == MODE_STX)
                        mask[EN_TX] = 1'b0;
                    mode = MODE_READY;
                end else if (it.status_flags[FLG_NACK]) begin
                    if (mode == MODE_MTX || mode == MODE_MRX) begin
                        r.ack_actions[ACK_NACK] = 1'b1;
                        count = '0;
                        mode  = MODE_READY;
                    end else if (mode == MODE_STX) begin
                        // slave keeps sending filler when nacked at zero count
                        r.ack_actions[ACK_NACK] = 1'b1;
                        if (count != 8'd0)
                            mode = MODE_READY;
                        count = '0;
                    end
                end
            end
            r.irq_enables     = mask;
            r.transfer_state  = mode;
            r.remaining_bytes = count;
            awaited.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("mismatch on %0s at result %0d: expected %0h, got %0h",
                             name, n_outcomes, want, got);
            end
        endfunction

        function void check_outcome(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("result %h arrived with nothing outstanding", got);
                return;
            end
            want = awaited.pop_front();
            compare_field("start_accepted", 8'(want.start_accepted), 8'(got.start_accepted));
            compare_field("start_request", 8'(want.start_request), 8'(got.start_request));
            compare_field("start_address", 8'(want.start_address), 8'(got.start_address));
            compare_field("tx_write", 8'(want.tx_write), 8'(got.tx_write));
            compare_field("tx_value", want.tx_value, got.tx_value);
            compare_field("rx_store", 8'(want.rx_store), 8'(got.rx_store));
            compare_field("rx_value", want.rx_value, got.rx_value);
            compare_field("ack_actions", 8'(want.ack_actions), 8'(got.ack_actions));
            compare_field("irq_enables", 8'(want.irq_enables), 8'(got.irq_enables));
            compare_field("transfer_state", 8'(want.transfer_state), 8'(got.transfer_state));
            compare_field("remaining_bytes", want.remaining_bytes, got.remaining_bytes);
            n_outcomes++;
        endfunction
    endclass

endpackage

// ----- test/i2c_transfer_event_sequencer_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer event sequencer testbench
// Directed corner transfers, then random start/event sequences with and without stalls
// ----------------------------------------------------------------------------
module i2c_transfer_event_sequencer_top_tb;
    import ites_pkg::*;
    import ites_tb_pkg::*;

    localparam logic [2:0] ACT_RESERVED    = 3'd7;
    localparam int unsigned ITEMS_PER_PHASE = 265;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_action;
    logic [7:0] s_transfer_length;
    logic [6:0] s_target_address;
    logic       s_bus_busy;
    logic [5:0] s_status_flags;
    logic [7:0] s_received_byte;
    logic [7:0] s_send_byte;
    logic       m_valid;
    logic       m_ready;
    logic       m_start_accepted;
    logic       m_start_request;
    logic [6:0] m_start_address;
    logic       m_tx_write;
    logic [7:0] m_tx_value;
    logic       m_rx_store;
    logic [7:0] m_rx_value;
    logic [3:0] m_ack_actions;
    logic [4:0] m_irq_enables;
    logic [2:0] m_transfer_state;
    logic [7:0] m_remaining_bytes;

    sequencer_scoreboard sb;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned items_sent;
    int unsigned drain_cycles;

    i2c_transfer_event_sequencer_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_transfer_length (s_transfer_length),
        .s_target_address  (s_target_address),
        .s_bus_busy        (s_bus_busy),
        .s_status_flags    (s_status_flags),
        .s_received_byte   (s_received_byte),
        .s_send_byte       (s_send_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_start_accepted  (m_start_accepted),
        .m_start_request   (m_start_request),
        .m_start_address   (m_start_address),
        .m_tx_write        (m_tx_write),
        .m_tx_value        (m_tx_value),
        .m_rx_store        (m_rx_store),
        .m_rx_value        (m_rx_value),
        .m_ack_actions     (m_ack_actions),
        .m_irq_enables     (m_irq_enables),
        .m_transfer_state  (m_transfer_state),
        .m_remaining_bytes (m_remaining_bytes)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #400000;
        $display("timeout with %0d transfers sent", items_sent);
        $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_outcome(result_t'({m_start_accepted, m_start_request, m_start_address,
                                        m_tx_write, m_tx_value, m_rx_store, m_rx_value,
                                        m_ack_actions, m_irq_enables, m_transfer_state,
                                        m_remaining_bytes}));
    end

    function automatic logic [5:0] flag_bit(int pos);
        return 6'(1 << pos);
    endfunction

    function automatic item_t make_item(logic [2:0] act, logic [7:0] len, logic [6:0] addr,
                                        logic busy, logic [5:0] flags, logic [7:0] rxb,
                                        logic [7:0] txb);
        item_t it;
        it.action          = act;
        it.transfer_length = len;
        it.target_address  = addr;
        it.bus_busy        = busy;
        it.status_flags    = flags;
        it.received_byte   = rxb;
        it.send_byte       = txb;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic drive_item(input item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid = 1'b1;
        {s_action, s_transfer_length, s_target_address, s_bus_busy, s_status_flags,
         s_received_byte, s_send_byte} = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(it);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic drive_event(input logic [5:0] flags, input logic [7:0] rxb,
                               input logic [7:0] txb);
        drive_item(make_item(ACT_EVENT, 8'($urandom), 7'($urandom), 1'($urandom),
                             flags, rxb, txb));
    endtask

    task automatic run_directed();
        drive_event('0, 8'hff, 8'hff);
        drive_item(make_item(ACT_MASTER_WRITE, 8'd2, 7'h7f, 1'b0, '0, 8'h00, 8'h00));
        drive_item(make_item(ACT_MASTER_READ, 8'd9, 7'h12, 1'b0, 6'h3f, 8'h00, 8'h00));
        drive_event(flag_bit(FLG_TXE), 8'h00, 8'hff);
        drive_event(flag_bit(FLG_RXNE), 8'hff, 8'h00);
        drive_event(flag_bit(FLG_TXE) | flag_bit(FLG_DIR), 8'h00, 8'h00);
        drive_item(make_item(ACT_MASTER_READ, 8'd1, 7'h00, 1'b1, '0, 8'h00, 8'h00));
        drive_item(make_item(ACT_MASTER_READ, 8'd1, 7'h00, 1'b0, '0, 8'h00, 8'h00));
        drive_event(flag_bit(FLG_RXNE) | flag_bit(FLG_STOP), 8'haa, 8'h00);
        drive_item(make_item(ACT_SLAVE_SEND, 8'd0, 7'h2a, 1'b0, '0, 8'h00, 8'h00));
        drive_event(flag_bit(FLG_TXE), 8'h00, 8'h5a);
        // nack at zero count leaves the slave transmitting
        drive_event(flag_bit(FLG_NACK), 8'h00, 8'h00);
        drive_event(flag_bit(FLG_ADDR) | flag_bit(FLG_DIR), 8'h00, 8'h00);
        drive_event(6'h1f, 8'h00, 8'h00);
        drive_event(flag_bit(FLG_STOP) | flag_bit(FLG_NACK), 8'h00, 8'h00);
        drive_item(make_item(ACT_SLAVE_RECEIVE, 8'hff, 7'h55, 1'b0, '0, 8'h00, 8'h00));
        drive_event(flag_bit(FLG_NACK), 8'h00, 8'h00);
        drive_event(flag_bit(FLG_RXNE), 8'h55, 8'h00);
        drive_event(flag_bit(FLG_STOP), 8'h00, 8'h00);
        drive_event(flag_bit(FLG_NACK), 8'h00, 8'h00);
        drive_item(make_item(ACT_RESERVED, 8'hff, 7'h7f, 1'b0, 6'h3f, 8'hff, 8'hff));
        drive_item(make_item(ACT_MASTER_WRITE, 8'd0, 7'h55, 1'b0, '0, 8'h00, 8'h00));
        drive_event(flag_bit(FLG_TXE), 8'h00, 8'h81);
        drive_event(flag_bit(FLG_NACK) | flag_bit(FLG_DIR), 8'h00, 8'h00);
        drive_item(make_item(ACT_SLAVE_SEND, 8'd3, 7'h01, 1'b0, '0, 8'h00, 8'h00));
        drive_event(flag_bit(FLG_NACK), 8'h00, 8'h00);
    endtask

    // one start followed by events that mostly fit the transfer kind
    task automatic run_transfer();
        logic [2:0]  kind;
        int unsigned len;
        int unsigned n_events;
        int unsigned pick;
        int unsigned pos;
        logic [5:0]  flags;
        kind = 3'($urandom_range(ACT_SLAVE_RECEIVE, ACT_MASTER_WRITE));
        len  = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(6);
        drive_item(make_item(kind, 8'(len), 7'($urandom), $urandom_range(9) == 0, 6'($urandom),
                             8'($urandom), 8'($urandom)));
        n_events = $urandom_range(0, (len > 10) ? 40 : len + 2);
        for (int i = 0; i < n_events; i++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                pos = (kind == ACT_MASTER_WRITE || kind == ACT_SLAVE_SEND) ? FLG_TXE : FLG_RXNE;
            else if (pick < 80)
                pos = FLG_ADDR;
            else if (pick < 90)
                pos = FLG_NACK;
            else
                pos = $urandom_range(FLG_DIR, FLG_ADDR);
            flags = flag_bit(pos);
            // lower-priority bits riding along must not change the outcome (bar DIR on an address event)
            if ($urandom_range(2) == 0)
                flags |= 6'($urandom & ~((32'd2 << pos) - 1));
            drive_event(flags, 8'($urandom), 8'($urandom));
        end
        if ($urandom_range(3) != 0)
            drive_event(flag_bit(FLG_STOP) | 6'($urandom & 32'h30), 8'($urandom), 8'($urandom));
    endtask

    task automatic run_phase(input int unsigned sp, input int unsigned rp);
        int unsigned target;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        target = items_sent + ITEMS_PER_PHASE;
        while (items_sent < target) begin
            if ($urandom_range(99) < 15)
                drive_item(make_item(($urandom_range(19) == 0) ?
                                     3'($urandom_range(ACT_RESERVED, ACT_EVENT + 1)) :
                                     3'($urandom_range(ACT_EVENT)),
                                     8'($urandom), 7'($urandom), 1'($urandom), 6'($urandom),
                                     8'($urandom), 8'($urandom)));
            else
                run_transfer();
        end
    endtask

    initial begin
        sb                = new();
        items_sent        = 0;
        send_idle_pct     = 12;
        recv_idle_pct     = 50;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_action          = '0;
        s_transfer_length = '0;
        s_target_address  = '0;
        s_bus_busy        = 1'b0;
        s_status_flags    = '0;
        s_received_byte   = '0;
        s_send_byte       = '0;
        m_ready           = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        run_directed();
        run_phase(12, 50);
        run_phase(50, 12);
        run_phase(0, 0);
        s_valid = 1'b0;

        drain_cycles = 0;
        while (sb.awaited.size() != 0 && drain_cycles < 2000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (8) @(posedge aclk);

        $display("sent %0d transfers, checked %0d results, %0d starts taken",
                 items_sent, sb.n_outcomes, sb.n_starts);
        $display("tx writes %0d (filler %0d), rx stores %0d, stops %0d, mismatches %0d",
                 sb.n_tx, sb.n_filler, sb.n_rx, sb.n_stops, sb.n_errors);
        if (sb.awaited.size() != 0)
            $display("%0d results never arrived", sb.awaited.size());
        if (sb.n_errors == 0 && sb.awaited.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ites_pkg.sv
rtl/ites_step.sv
rtl/i2c_transfer_event_sequencer_top.sv
rtl/ites_checker.sv
test/ites_tb_pkg.sv
test/i2c_transfer_event_sequencer_top_tb.sv
